[sv/circular_list_with_cursor_top_macros.svh]
// Assertion shorthands shared by the list controller and datapath.
// Both expect signals named clock and reset in the module that uses them.
`ifndef CIRCULAR_LIST_WITH_CURSOR_TOP_MACROS_SVH
`define CIRCULAR_LIST_WITH_CURSOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("circular list same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CLC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("circular list next-cycle check failed");

`endif

[sv/clc_pkg.sv]
package clc_pkg;

   localparam int DefaultDepth     = 16;
   localparam int DefaultDataWidth = 32;
   localparam int OpcodeWidth      = 3;
   localparam int StatusWidth      = 2;

   typedef enum logic [OpcodeWidth-1:0] {
      OP_INS_TAIL  = 3'd0,
      OP_INS_FRONT = 3'd1,
      OP_FIRST     = 3'd2,
      OP_NEXT      = 3'd3,
      OP_REMOVE    = 3'd4
   } opcode_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_NOCUR = 2'd3
   } status_type;

   // Commands from the controller to the datapath, one step per cycle unless the response stalls.
   typedef struct packed {
      logic       capture;        // latch the insert value of the accepted beat
      logic       alloc;          // pick a free slot, read the tail's link
      logic       place;          // write the new node's value and link
      logic       splice;         // hook the new node behind the tail
      logic       splice_to_tail; // the new node becomes the tail
      logic       hop;            // read the link of the tail or the cursor
      logic       hop_from_tail;
      logic       fetch;          // move the cursor, read its value
      logic       rm_read;        // read the cursor node's value and link
      logic       rm_write;       // unlink the cursor node and free its slot
      logic       load_rsp;       // fill the response register
      status_type rsp_status;
      logic       rsp_use_value;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic count_one;
      logic cursor_valid;
      logic cursor_at_prev;
   } stat_type;

endpackage

[sv/clc_if.sv]
interface clc_req_if #(
   parameter int DATA_WIDTH = clc_pkg::DefaultDataWidth
);
   logic                            valid;
   logic                            ready;
   logic [clc_pkg::OpcodeWidth-1:0] opcode;
   logic [DATA_WIDTH-1:0]           value_in;

   modport source (output valid, output opcode, output value_in, input ready);
   modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

interface clc_rsp_if #(
   parameter int DATA_WIDTH  = clc_pkg::DefaultDataWidth,
   parameter int COUNT_WIDTH = $clog2(clc_pkg::DefaultDepth + 1)
);
   logic                            valid;
   logic                            ready;
   logic [DATA_WIDTH-1:0]           value_out;
   logic [clc_pkg::StatusWidth-1:0] status;
   logic [COUNT_WIDTH-1:0]          item_count;

   modport source (output valid, output value_out, output status, output item_count,
                   input ready);
   modport sink   (input valid, input value_out, input status, input item_count,
                   output ready);
endinterface

[sv/clc_ctrl.sv]
`include "circular_list_with_cursor_top_macros.svh"

module clc_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [clc_pkg::OpcodeWidth-1:0] req_opcode,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  clc_pkg::stat_type               stat,
   output clc_pkg::cmd_type                cmd
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_ALLOC  = 9'b000000010,
      S_LINK   = 9'b000000100,
      S_SPLICE = 9'b000001000,
      S_HOP    = 9'b000010000,
      S_FETCH  = 9'b000100000,
      S_RM_RD  = 9'b001000000,
      S_RM_WR  = 9'b010000000,
      S_RESP   = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   clc_pkg::status_type status_ff, status_in;
   logic                use_value_ff, use_value_in;
   logic                hop_tail_ff, hop_tail_in;
   logic                to_tail_ff, to_tail_in;
   logic                rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      use_value_in = use_value_ff;
      hop_tail_in  = hop_tail_ff;
      to_tail_in   = to_tail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.rsp_status = clc_pkg::ST_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture  = 1'b1;
               hop_tail_in  = (req_opcode == clc_pkg::OP_FIRST);
               to_tail_in   = (req_opcode == clc_pkg::OP_INS_TAIL);
               use_value_in = 1'b0;
               status_in    = clc_pkg::ST_OK;
               state_in     = S_RESP;
               unique case (req_opcode) inside
                  clc_pkg::OP_INS_TAIL, clc_pkg::OP_INS_FRONT: begin
                     if (stat.count_full) begin
                        status_in = clc_pkg::ST_FULL;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  clc_pkg::OP_FIRST: begin
                     if (stat.count_zero) begin
                        status_in = clc_pkg::ST_EMPTY;
                     end else begin
                        use_value_in = 1'b1;
                        state_in     = S_HOP;
                     end
                  end
                  clc_pkg::OP_NEXT: begin
                     if (stat.count_zero) begin
                        status_in = clc_pkg::ST_EMPTY;
                     end else if (!stat.cursor_valid) begin
                        status_in = clc_pkg::ST_NOCUR;
                     end else begin
                        use_value_in = 1'b1;
                        state_in     = S_HOP;
                     end
                  end
                  clc_pkg::OP_REMOVE: begin
                     if (stat.count_zero) begin
                        status_in = clc_pkg::ST_EMPTY;
                     end else if (!stat.cursor_valid) begin
                        status_in = clc_pkg::ST_NOCUR;
                     end else if (stat.cursor_at_prev && !stat.count_one) begin
                        status_in = clc_pkg::ST_NOCUR;
                     end else begin
                        use_value_in = 1'b1;
                        state_in     = S_RM_RD;
                     end
                  end
                  default: begin
                     status_in = clc_pkg::ST_OK;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in  = S_LINK;
         end
         S_LINK: begin
            cmd.place = 1'b1;
            state_in  = S_SPLICE;
         end
         S_SPLICE: begin
            cmd.splice         = 1'b1;
            cmd.splice_to_tail = to_tail_ff;
            state_in           = S_RESP;
         end
         S_HOP: begin
            cmd.hop           = 1'b1;
            cmd.hop_from_tail = hop_tail_ff;
            state_in          = S_FETCH;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_RESP;
         end
         S_RM_RD: begin
            cmd.rm_read = 1'b1;
            state_in    = S_RM_WR;
         end
         S_RM_WR: begin
            cmd.rm_write = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp      = 1'b1;
               cmd.rsp_status    = status_ff;
               cmd.rsp_use_value = use_value_ff;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= clc_pkg::ST_OK;
         use_value_ff <= 1'b0;
         hop_tail_ff  <= 1'b0;
         to_tail_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         use_value_ff <= use_value_in;
         hop_tail_ff  <= hop_tail_in;
         to_tail_ff   <= to_tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CLC_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state_ff != S_IDLE)
   `CLC_ASSERT_SAME(a_rsp_not_overwritten, cmd.load_rsp, !rsp_valid_ff || rsp_ready)
   `CLC_ASSERT_NEXT(a_rsp_after_load, cmd.load_rsp, rsp_valid_ff && state_ff == S_IDLE)

endmodule

[sv/clc_dpath.sv]
`include "circular_list_with_cursor_top_macros.svh"

module clc_dpath #(
   parameter int DEPTH      = clc_pkg::DefaultDepth,
   parameter int DATA_WIDTH = clc_pkg::DefaultDataWidth
) (
   input  logic                            clock,
   input  logic                            reset,
   input  clc_pkg::cmd_type                cmd,
   output clc_pkg::stat_type               stat,
   input  logic [DATA_WIDTH-1:0]           req_value_in,
   output logic [DATA_WIDTH-1:0]           rsp_value_out,
   output logic [clc_pkg::StatusWidth-1:0] rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]      rsp_item_count
);

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   // Node storage and the stack of released slots. Slots never used yet
   // come from fresh_ff, so nothing here needs clearing after reset.
   logic [DATA_WIDTH-1:0] value_ram [DEPTH];
   logic [IDX_W-1:0]      link_ram  [DEPTH];
   logic [IDX_W-1:0]      stack_ram [DEPTH];

   logic [DATA_WIDTH-1:0] value_rd_ff;
   logic [IDX_W-1:0]      link_rd_ff;
   logic [IDX_W-1:0]      stack_rd_ff;

   logic                  value_we, value_re;
   logic [IDX_W-1:0]      value_wa, value_ra;
   logic                  link_we, link_re;
   logic [IDX_W-1:0]      link_wa, link_ra, link_wd;
   logic                  stack_we, stack_re;
   logic [IDX_W-1:0]      stack_wa, stack_ra;

   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [IDX_W-1:0]      cursor_ff, cursor_in;
   logic [IDX_W-1:0]      prev_ff, prev_in;
   logic                  cursor_valid_ff, cursor_valid_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    fresh_ff, fresh_in;
   logic [COUNT_W-1:0]    sp_ff, sp_in;
   logic [IDX_W-1:0]      new_slot_ff, new_slot_in;
   logic                  from_stack_ff, from_stack_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [clc_pkg::StatusWidth-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic [COUNT_W-1:0]    sp_dec;
   logic [IDX_W-1:0]      place_slot;

   assign sp_dec     = sp_ff - COUNT_W'(1);
   assign place_slot = from_stack_ff ? stack_rd_ff : new_slot_ff;

   assign stat.count_zero     = (count_ff == '0);
   assign stat.count_full     = (count_ff == COUNT_W'(DEPTH));
   assign stat.count_one      = (count_ff == COUNT_W'(1));
   assign stat.cursor_valid   = cursor_valid_ff;
   assign stat.cursor_at_prev = (cursor_ff == prev_ff);

   assign rsp_value_out  = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_item_count = rsp_count_ff;

   // Memory port selection.
   always_comb begin
      value_we = cmd.place;
      value_wa = place_slot;
      value_re = cmd.fetch || cmd.rm_read;
      value_ra = cmd.fetch ? link_rd_ff : cursor_ff;

      link_we = 1'b0;
      link_wa = place_slot;
      link_wd = link_rd_ff;
      if (cmd.place) begin
         link_we = 1'b1;
         link_wa = place_slot;
         link_wd = stat.count_zero ? place_slot : link_rd_ff;
      end else if (cmd.splice) begin
         link_we = 1'b1;
         link_wa = tail_ff;
         link_wd = new_slot_ff;
      end else if (cmd.rm_write) begin
         link_we = 1'b1;
         link_wa = prev_ff;
         link_wd = link_rd_ff;
      end

      link_re = cmd.alloc || cmd.hop || cmd.rm_read;
      link_ra = cursor_ff;
      if (cmd.alloc || (cmd.hop && cmd.hop_from_tail)) begin
         link_ra = tail_ff;
      end

      stack_re = cmd.alloc && (sp_ff != '0);
      stack_ra = sp_dec[IDX_W-1:0];
      stack_we = cmd.rm_write;
      stack_wa = sp_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (value_we) begin
         value_ram[value_wa] <= val_ff;
      end
      if (value_re) begin
         value_rd_ff <= value_ram[value_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_ram[link_wa] <= link_wd;
      end
      if (link_re) begin
         link_rd_ff <= link_ram[link_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_ram[stack_wa] <= cursor_ff;
      end
      if (stack_re) begin
         stack_rd_ff <= stack_ram[stack_ra];
      end
   end

   // Pointer and count updates.
   always_comb begin
      val_in          = val_ff;
      tail_in         = tail_ff;
      cursor_in       = cursor_ff;
      prev_in         = prev_ff;
      cursor_valid_in = cursor_valid_ff;
      count_in        = count_ff;
      fresh_in        = fresh_ff;
      sp_in           = sp_ff;
      new_slot_in     = new_slot_ff;
      from_stack_in   = from_stack_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_count_in    = rsp_count_ff;

      if (cmd.capture) begin
         val_in = req_value_in;
      end

      if (cmd.alloc) begin
         from_stack_in = (sp_ff != '0);
         if (sp_ff != '0) begin
            sp_in = sp_dec;
         end else begin
            new_slot_in = fresh_ff[IDX_W-1:0];
            fresh_in    = fresh_ff + COUNT_W'(1);
         end
      end

      if (cmd.place) begin
         new_slot_in = place_slot;
      end

      if (cmd.splice) begin
         count_in = count_ff + COUNT_W'(1);
         if (cmd.splice_to_tail || stat.count_zero) begin
            tail_in = new_slot_ff;
         end
         // Keep the cursor's predecessor linked to the cursor.
         if (cursor_valid_ff && prev_ff == tail_ff && cursor_ff != prev_ff) begin
            prev_in = new_slot_ff;
         end
      end

      if (cmd.hop) begin
         prev_in = cmd.hop_from_tail ? tail_ff : cursor_ff;
      end

      if (cmd.fetch) begin
         cursor_in       = link_rd_ff;
         cursor_valid_in = 1'b1;
      end

      if (cmd.rm_write) begin
         sp_in = sp_ff + COUNT_W'(1);
         if (stat.count_one) begin
            count_in        = '0;
            cursor_valid_in = 1'b0;
            cursor_in       = '0;
            prev_in         = '0;
            tail_in         = '0;
         end else begin
            count_in  = count_ff - COUNT_W'(1);
            cursor_in = prev_ff;
            if (cursor_ff == tail_ff) begin
               tail_in = prev_ff;
            end
         end
      end

      if (cmd.load_rsp) begin
         rsp_value_in  = cmd.rsp_use_value ? value_rd_ff : '0;
         rsp_status_in = cmd.rsp_status;
         rsp_count_in  = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff         <= '0;
         cursor_ff       <= '0;
         prev_ff         <= '0;
         cursor_valid_ff <= 1'b0;
         count_ff        <= '0;
         fresh_ff        <= '0;
         sp_ff           <= '0;
         from_stack_ff   <= 1'b0;
      end else begin
         tail_ff         <= tail_in;
         cursor_ff       <= cursor_in;
         prev_ff         <= prev_in;
         cursor_valid_ff <= cursor_valid_in;
         count_ff        <= count_in;
         fresh_ff        <= fresh_in;
         sp_ff           <= sp_in;
         from_stack_ff   <= from_stack_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff        <= val_in;
      new_slot_ff   <= new_slot_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   `CLC_ASSERT_SAME(a_slot_accounting, !cmd.place && !cmd.splice, fresh_ff == sp_ff + count_ff)
   `CLC_ASSERT_SAME(a_empty_no_cursor, count_ff == '0, !cursor_valid_ff)
   `CLC_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= COUNT_W'(DEPTH))

endmodule

[sv/circular_list_with_cursor_top.sv]
// An accepted insert steps through the alloc, link and splice states, first and next
// through hop and fetch, and remove through the remove read and write states; each then
// loads the rsp beat in the response state, which a refused or unknown operation enters
// directly. No new req beat is taken before that load; each hop is a registered memory read.
// Reset is synchronous and active high; it empties the list at once with no clearing pass,
// because values read from node storage are used only at slots that an insert has written.
module circular_list_with_cursor_top #(
   parameter int DEPTH      = clc_pkg::DefaultDepth,
   parameter int DATA_WIDTH = clc_pkg::DefaultDataWidth
) (
   input  logic      clock,
   input  logic      reset,
   clc_req_if.sink   req_bus,
   clc_rsp_if.source rsp_bus
);

   // The list lives in a node pool: each node has a value and a link to the
   // next node, and the tail's link is the head. The cursor walks the ring
   // together with its predecessor so that the cursor's node can be unlinked
   // without a search.
   localparam int COUNT_W = $clog2(DEPTH + 1);

   clc_pkg::cmd_type  cmd;
   clc_pkg::stat_type stat;

   logic                            req_ready;
   logic                            rsp_valid;
   logic [DATA_WIDTH-1:0]           rsp_value;
   logic [clc_pkg::StatusWidth-1:0] rsp_status;
   logic [COUNT_W-1:0]              rsp_count;

   // The controller sequences one operation at a time. A req beat is taken
   // only in its idle state, but the response register lets it take the next
   // beat while the previous rsp beat still waits for the consumer.
   clc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_ready),
      .req_opcode (req_bus.opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_bus.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath holds the node memories, the free-slot stack, the list
   // pointers and the response register.
   clc_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_value_in   (req_bus.value_in),
      .rsp_value_out  (rsp_value),
      .rsp_status     (rsp_status),
      .rsp_item_count (rsp_count)
   );

   assign req_bus.ready      = req_ready;
   assign rsp_bus.valid      = rsp_valid;
   assign rsp_bus.value_out  = rsp_value;
   assign rsp_bus.status     = rsp_status;
   assign rsp_bus.item_count = rsp_count;

endmodule
